// ----- rtl/sbol_pkg.sv -----
package sbol_pkg;

  localparam int CAPACITY     = 1024;
  localparam int ADDR_W       = $clog2(CAPACITY);
  localparam int CNT_W        = $clog2(CAPACITY + 1);
  localparam int KEY_BITS     = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int SEQ_W        = 32;
  localparam int WORD_W       = 1 + KEY_BITS + SEQ_W + PAYLOAD_BITS;
  localparam int DRAW_W       = 16;
  localparam int EPS_W        = 17;
  localparam int TAU_W        = 16;
  localparam int WGT_W        = 25;
  localparam int VAL_W        = 35;
  localparam int PROD_W       = 52;
  localparam int FRAC_W       = 16;
  localparam int NUM_SCALE    = 256 * 94548;
  localparam int SCALE_W      = $clog2(NUM_SCALE + 1);
  localparam int NUM_W        = KEY_BITS + SCALE_W;
  localparam int SHIFT_W      = $clog2(WGT_W);
  localparam int MUL_CNT_W    = $clog2(EPS_W);

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic [2:0] REG_TEMP = 3'd0;
  localparam logic [2:0] REG_EPS  = 3'd1;
  localparam logic [2:0] REG_SIZE = 3'd2;
  localparam logic [2:0] REG_WGT  = 3'd3;
  localparam logic [2:0] REG_TIES = 3'd4;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SCAN, S_EVAL, S_VALUE, S_WWAIT, S_ACC,
    S_MUL, S_MEND, S_PSET, S_WRITE, S_DONE
  } state_e;

  typedef enum logic [1:0] {
    SCAN_FREE, SCAN_BUCKET, SCAN_RAND, SCAN_OLD
  } scan_mode_e;

  typedef enum logic [1:0] {
    PH_FIRST, PH_TOTAL, PH_CUM
  } phase_e;

  typedef enum logic [1:0] {
    W_IDLE, W_DIV, W_EXP, W_DONE
  } w_state_e;

  function automatic logic [31:0] halving_f(input logic [3:0] idx);
    logic [31:0] h;
    case (idx)
      4'd0:  h = 32'd3037000500;
      4'd1:  h = 32'd3611622603;
      4'd2:  h = 32'd3938502376;
      4'd3:  h = 32'd4112874773;
      4'd4:  h = 32'd4202935003;
      4'd5:  h = 32'd4248701952;
      4'd6:  h = 32'd4271771996;
      4'd7:  h = 32'd4283353945;
      4'd8:  h = 32'd4289156690;
      4'd9:  h = 32'd4292061010;
      4'd10: h = 32'd4293513907;
      4'd11: h = 32'd4294240540;
      4'd12: h = 32'd4294603903;
      4'd13: h = 32'd4294785596;
      4'd14: h = 32'd4294876445;
      default: h = 32'd4294921870;
    endcase
    return h;
  endfunction

endpackage

// ----- rtl/sbol_ram.sv -----
module sbol_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/sbol_weight.sv -----
module sbol_weight (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [sbol_pkg::KEY_BITS-1:0] key_i,
  input  logic [sbol_pkg::TAU_W-1:0]    tau_i,
  output logic                          done_o,
  output logic [sbol_pkg::WGT_W-1:0]    weight_o
);
  import sbol_pkg::*;

  w_state_e state_q, state_d;
  logic [NUM_W-1:0]   num_q, num_d;
  logic [NUM_W-1:0]   quot_q, quot_d;
  logic [TAU_W:0]     rem_q, rem_d;
  logic [5:0]         step_q, step_d;
  logic [32:0]        m_q, m_d;
  logic [SHIFT_W-1:0] n_q, n_d;
  logic [TAU_W:0]     tau_eff;
  logic [TAU_W:0]     rem_sh;
  logic [63:0]        prod;
  logic [NUM_W-FRAC_W-1:0] n_full;
  logic [31:0]        h;

  assign tau_eff = (tau_i == '0) ? (TAU_W+1)'(1) : {1'b0, tau_i};
  assign rem_sh  = {rem_q[TAU_W-1:0], num_q[NUM_W-1]};
  assign n_full  = quot_q[NUM_W-1:FRAC_W];
  assign h       = halving_f(step_q[3:0]);
  assign prod    = m_q[31:0] * h;

  always_comb begin
    state_d = state_q;
    case (state_q)
      W_IDLE: if (start_i) state_d = W_DIV;
      W_DIV: begin
        if (step_q == 6'(NUM_W - 1)) begin
          state_d = W_EXP;
        end
      end
      W_EXP: begin
        if (n_full >= (NUM_W-FRAC_W)'(WGT_W)) begin
          state_d = W_DONE;
        end else if (step_q == 6'(FRAC_W - 1)) begin
          state_d = W_DONE;
        end
      end
      W_DONE:  state_d = W_IDLE;
      default: state_d = W_IDLE;
    endcase
  end

  always_comb begin
    num_d  = num_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    step_d = step_q;
    m_d    = m_q;
    n_d    = n_q;
    case (state_q)
      W_IDLE: begin
        num_d  = NUM_W'(key_i) * NUM_W'(NUM_SCALE);
        quot_d = '0;
        rem_d  = '0;
        step_d = '0;
      end
      W_DIV: begin
        num_d = num_q << 1;
        if (rem_sh >= tau_eff) begin
          rem_d  = rem_sh - tau_eff;
          quot_d = {quot_q[NUM_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          quot_d = {quot_q[NUM_W-2:0], 1'b0};
        end
        step_d = (step_q == 6'(NUM_W - 1)) ? '0 : step_q + 6'd1;
        m_d    = 33'h1_0000_0000;
      end
      W_EXP: begin
        n_d = n_full[SHIFT_W-1:0];
        if (n_full >= (NUM_W-FRAC_W)'(WGT_W)) begin
          m_d = '0;
        end else if (quot_q[4'd15 - step_q[3:0]]) begin
          m_d = m_q[32] ? {1'b0, h} : {1'b0, prod[63:32]};
        end
        step_d = step_q + 6'd1;
      end
      default: ;
    endcase
  end

  assign done_o   = (state_q == W_DONE);
  assign weight_o = m_q[32:8] >> n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
    step_q <= step_d;
    m_q    <= m_d;
    n_q    <= n_d;
  end

endmodule

// ----- rtl/softmin_bucket_open_list.sv -----
// Priority store with softmin bucket removal.
// Input beats (s_axis) carry an operation in tuser: insert, remove or clear.
// Every accepted input beat yields exactly one output beat (m_axis) carrying
// the removed payload, a removed flag, an empty flag and a status code.
// Configuration goes through the APB port; write it only while idle.
// Steps per operation, with C the capacity of 1024 slots:
//   insert      one sweep of the slot memory for a free slot, then a write
//   remove      lowest bucket sweep, then entry pick sweep
//   randomized bucket choice adds, for B buckets, up to 2B + 1 sweeps of C
//   slots plus a weight evaluation per bucket visit unless REG_WGT is set
//   clear       one write sweep
// The slot memory has one read and one write port; every sweep reads one
// slot per cycle over all C slots, so capacity, not occupancy, sets its length.
// One item is in flight at a time. The result sits in an output register,
// so a stalled receiver holds only the result, and the next input beat is
// taken once the block is idle. After reset the block clears every slot of the
// memory with s_axis_tready low; configuration writes are taken throughout.
module softmin_bucket_open_list (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // key, payload, draw_unit, draw_pick
  input  logic [1:0]  s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // removed_payload
  output logic [3:0]  m_axis_tuser,   // removed_valid, now_empty, status
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sbol_pkg::*;

  state_e     state_q, state_d;
  scan_mode_e mode_q, mode_d;
  phase_e     phase_q, phase_d;

  logic [TAU_W-1:0] cfg_temp_q;
  logic [EPS_W-1:0] cfg_eps_q;
  logic cfg_size_q, cfg_wgt_q, cfg_ties_q;

  logic [1:0]              func_q, func_d;
  logic [KEY_BITS-1:0]     key_q, key_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;
  logic [DRAW_W-1:0]       du_q, du_d, dp_q, dp_d;

  logic [ADDR_W:0]         scan_addr_q, scan_addr_d;
  logic                    rd_vld_q, rd_vld_d;
  logic [ADDR_W-1:0]       rd_addr_q, rd_addr_d;
  logic                    fnd_q, fnd_d;
  logic [KEY_BITS-1:0]     best_q, best_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [ADDR_W-1:0]       hit_q, hit_d;
  logic [PAYLOAD_BITS-1:0] hit_pay_q, hit_pay_d;
  logic [SEQ_W-1:0]        age_q, age_d;
  logic                    have_prev_q, have_prev_d;
  logic [KEY_BITS-1:0]     prev_q, prev_d;
  logic [KEY_BITS-1:0]     ck_q, ck_d, bk_key_q, bk_key_d;
  logic [CNT_W-1:0]        cc_q, cc_d, bk_cnt_q, bk_cnt_d, target_q, target_d;
  logic                    rnd_q, rnd_d;
  logic [VAL_W-1:0]        total_q, total_d, cum_q, cum_d, val_q, val_d;
  logic [1:0]              nb_q, nb_d;
  logic [PROD_W-1:0]       mul_acc_q, mul_acc_d, mul_a_q, mul_a_d, prod_a_q, prod_a_d;
  logic [EPS_W-1:0]        mul_b_q, mul_b_d;
  logic [MUL_CNT_W-1:0]    mul_cnt_q, mul_cnt_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [SEQ_W-1:0]        seq_q, seq_d;
  logic                    clr_item_q, clr_item_d;
  logic [PAYLOAD_BITS-1:0] res_pay_q, res_pay_d;
  logic                    res_vld_q, res_vld_d;
  logic [1:0]              res_st_q, res_st_d;
  logic                    out_vld_q, out_vld_d;
  logic [31:0]             out_data_q;
  logic [3:0]              out_user_q;

  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [WORD_W-1:0]       ram_wdata, ram_rdata;
  logic                    rd_u;
  logic [KEY_BITS-1:0]     rd_k;
  logic [SEQ_W-1:0]        rd_s, rd_age;
  logic [PAYLOAD_BITS-1:0] rd_p;
  logic                    wgt_start;
  logic                    wgt_done;
  logic [WGT_W-1:0]        w_val;
  logic                    in_fire, load, scan_end, cfg_we, rnd_now;
  logic [CNT_W-1:0]        size_fac;
  logic [CNT_W+WGT_W-1:0]  wv_prod;
  logic [CNT_W+DRAW_W-1:0] tgt_prod;

  sbol_ram #(.Width(WORD_W), .Depth(CAPACITY)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (scan_addr_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  sbol_weight u_wgt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (wgt_start),
    .key_i    (bk_key_q),
    .tau_i    (cfg_temp_q),
    .done_o   (wgt_done),
    .weight_o (w_val)
  );

  assign rd_u     = ram_rdata[WORD_W-1];
  assign rd_k     = ram_rdata[WORD_W-2 -: KEY_BITS];
  assign rd_s     = ram_rdata[PAYLOAD_BITS +: SEQ_W];
  assign rd_p     = ram_rdata[PAYLOAD_BITS-1:0];
  assign rd_age   = seq_q - rd_s;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign scan_end = scan_addr_q[ADDR_W] && !rd_vld_q;
  assign rnd_now  = {1'b0, du_q} <= cfg_eps_q;
  assign size_fac = cfg_size_q ? CNT_W'(1) : bk_cnt_q;
  assign wv_prod  = size_fac * w_val;
  assign tgt_prod = dp_q * cc_q;
  assign cfg_we   = psel && penable && pwrite && pready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR: begin
        if (scan_addr_q == (ADDR_W+1)'(CAPACITY - 1)) begin
          state_d = clr_item_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          case (s_axis_tuser)
            FUNC_INSERT: state_d = (count_q >= CNT_W'(CAPACITY)) ? S_DONE : S_SCAN;
            FUNC_REMOVE: state_d = S_SCAN;
            FUNC_CLEAR:  state_d = S_CLR;
            default:     state_d = S_DONE;
          endcase
        end
      end
      S_SCAN: if (scan_end) state_d = S_EVAL;
      S_EVAL: begin
        case (mode_q)
          SCAN_FREE: state_d = fnd_q ? S_WRITE : S_DONE;
          SCAN_BUCKET: begin
            case (phase_q)
              PH_FIRST: begin
                if (!fnd_q) begin
                  state_d = S_DONE;
                end else begin
                  state_d = (rnd_now && !cfg_ties_q) ? S_VALUE : S_PSET;
                end
              end
              PH_TOTAL: begin
                if (fnd_q) begin
                  state_d = S_VALUE;
                end else begin
                  state_d = (nb_q == 2'd2) ? S_MUL : S_PSET;
                end
              end
              default: state_d = fnd_q ? S_VALUE : S_PSET;
            endcase
          end
          default: state_d = S_WRITE;
        endcase
      end
      S_VALUE: state_d = cfg_wgt_q ? S_ACC : S_WWAIT;
      S_WWAIT: if (wgt_done) state_d = S_ACC;
      S_ACC:   state_d = (phase_q == PH_TOTAL) ? S_SCAN : S_MUL;
      S_MUL:   if (mul_cnt_q == MUL_CNT_W'(EPS_W - 1)) state_d = S_MEND;
      S_MEND: begin
        if (phase_q == PH_CUM && prod_a_q <= mul_acc_q) begin
          state_d = S_PSET;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_PSET:  state_d = S_SCAN;
      S_WRITE: state_d = S_DONE;
      S_DONE:  if (!out_vld_q || m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    wgt_start     = (state_q == S_VALUE) && !cfg_wgt_q;
    load          = (state_q == S_DONE) && (!out_vld_q || m_axis_tready);
    ram_we        = 1'b0;
    ram_waddr     = scan_addr_q[ADDR_W-1:0];
    ram_wdata     = '0;
    case (state_q)
      S_CLR: ram_we = 1'b1;
      S_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = hit_q;
        if (mode_q == SCAN_FREE) begin
          ram_wdata = {1'b1, key_q, seq_q, pay_q};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    mode_d = mode_q;       phase_d = phase_q;
    func_d = func_q;       key_d = key_q;      pay_d = pay_q;
    du_d = du_q;           dp_d = dp_q;
    scan_addr_d = scan_addr_q;
    rd_vld_d = (state_q == S_SCAN) && !scan_addr_q[ADDR_W];
    rd_addr_d = scan_addr_q[ADDR_W-1:0];
    fnd_d = fnd_q;         best_d = best_q;    cnt_d = cnt_q;
    hit_d = hit_q;         hit_pay_d = hit_pay_q;  age_d = age_q;
    have_prev_d = have_prev_q;  prev_d = prev_q;
    ck_d = ck_q;           cc_d = cc_q;        bk_key_d = bk_key_q;
    bk_cnt_d = bk_cnt_q;   target_d = target_q;    rnd_d = rnd_q;
    total_d = total_q;     cum_d = cum_q;      val_d = val_q;   nb_d = nb_q;
    mul_acc_d = mul_acc_q; mul_a_d = mul_a_q;  mul_b_d = mul_b_q;
    mul_cnt_d = mul_cnt_q; prod_a_d = prod_a_q;
    count_d = count_q;     seq_d = seq_q;      clr_item_d = clr_item_q;
    res_pay_d = res_pay_q; res_vld_d = res_vld_q;  res_st_d = res_st_q;

    if (state_d == S_SCAN && state_q != S_SCAN) begin
      scan_addr_d = '0;
      fnd_d       = 1'b0;
      cnt_d       = '0;
    end

    case (state_q)
      S_CLR: begin
        scan_addr_d = scan_addr_q + (ADDR_W+1)'(1);
        count_d     = '0;
      end
      S_IDLE: begin
        if (in_fire) begin
          func_d      = s_axis_tuser;
          key_d       = s_axis_tdata[15:0];
          pay_d       = s_axis_tdata[47:16];
          du_d        = s_axis_tdata[63:48];
          dp_d        = s_axis_tdata[79:64];
          res_pay_d   = '0;
          res_vld_d   = 1'b0;
          res_st_d    = STATUS_OK;
          mode_d      = SCAN_FREE;
          phase_d     = PH_FIRST;
          have_prev_d = 1'b0;
          clr_item_d  = 1'b1;
          scan_addr_d = '0;
          case (s_axis_tuser)
            FUNC_INSERT: begin
              if (count_q >= CNT_W'(CAPACITY)) res_st_d = STATUS_FULL;
            end
            FUNC_REMOVE: mode_d = SCAN_BUCKET;
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (!scan_addr_q[ADDR_W]) scan_addr_d = scan_addr_q + (ADDR_W+1)'(1);
        if (rd_vld_q) begin
          case (mode_q)
            SCAN_FREE: begin
              if (!rd_u && !fnd_q) begin
                fnd_d = 1'b1;
                hit_d = rd_addr_q;
              end
            end
            SCAN_BUCKET: begin
              if (rd_u && (!have_prev_q || rd_k > prev_q)) begin
                if (!fnd_q || rd_k < best_q) begin
                  fnd_d  = 1'b1;
                  best_d = rd_k;
                  cnt_d  = CNT_W'(1);
                end else if (rd_k == best_q) begin
                  cnt_d = cnt_q + CNT_W'(1);
                end
              end
            end
            SCAN_RAND: begin
              if (rd_u && rd_k == ck_q) begin
                if (!fnd_q && cnt_q == target_q) begin
                  fnd_d     = 1'b1;
                  hit_d     = rd_addr_q;
                  hit_pay_d = rd_p;
                end
                cnt_d = cnt_q + CNT_W'(1);
              end
            end
            default: begin
              if (rd_u && rd_k == ck_q && (!fnd_q || rd_age > age_q)) begin
                fnd_d     = 1'b1;
                hit_d     = rd_addr_q;
                hit_pay_d = rd_p;
                age_d     = rd_age;
              end
            end
          endcase
        end
      end
      S_EVAL: begin
        bk_key_d = best_q;
        bk_cnt_d = cnt_q;
        case (mode_q)
          SCAN_FREE: if (!fnd_q) res_st_d = STATUS_FULL;
          SCAN_BUCKET: begin
            case (phase_q)
              PH_FIRST: begin
                if (!fnd_q) begin
                  res_st_d = STATUS_EMPTY;
                end else begin
                  ck_d    = best_q;
                  cc_d    = cnt_q;
                  rnd_d   = rnd_now;
                  phase_d = PH_TOTAL;
                  total_d = '0;
                  nb_d    = '0;
                end
              end
              PH_TOTAL: begin
                if (!fnd_q && nb_q == 2'd2) begin
                  mul_acc_d = '0;
                  mul_a_d   = PROD_W'(total_q);
                  mul_b_d   = EPS_W'(du_q);
                  mul_cnt_d = '0;
                end
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      S_VALUE: val_d = VAL_W'(size_fac);
      S_WWAIT: if (wgt_done) val_d = wv_prod[VAL_W-1:0];
      S_ACC: begin
        if (phase_q == PH_TOTAL) begin
          total_d     = total_q + val_q;
          nb_d        = (nb_q == 2'd2) ? nb_q : nb_q + 2'd1;
          prev_d      = bk_key_q;
          have_prev_d = 1'b1;
        end else begin
          cum_d     = cum_q + val_q;
          mul_acc_d = '0;
          mul_a_d   = PROD_W'(cum_q + val_q);
          mul_b_d   = cfg_eps_q;
          mul_cnt_d = '0;
        end
      end
      S_MUL: begin
        if (mul_b_q[0]) mul_acc_d = mul_acc_q + mul_a_q;
        mul_a_d   = mul_a_q << 1;
        mul_b_d   = mul_b_q >> 1;
        mul_cnt_d = mul_cnt_q + MUL_CNT_W'(1);
      end
      S_MEND: begin
        if (phase_q == PH_TOTAL) begin
          prod_a_d    = mul_acc_q;
          phase_d     = PH_CUM;
          cum_d       = '0;
          have_prev_d = 1'b0;
        end else if (prod_a_q <= mul_acc_q) begin
          ck_d = bk_key_q;
          cc_d = bk_cnt_q;
        end else begin
          prev_d      = bk_key_q;
          have_prev_d = 1'b1;
        end
      end
      S_PSET: begin
        target_d = tgt_prod[DRAW_W +: CNT_W];
        mode_d   = rnd_q ? SCAN_RAND : SCAN_OLD;
      end
      S_WRITE: begin
        if (mode_q == SCAN_FREE) begin
          count_d = count_q + CNT_W'(1);
          seq_d   = seq_q + SEQ_W'(1);
        end else begin
          count_d   = count_q - CNT_W'(1);
          res_vld_d = 1'b1;
          res_pay_d = hit_pay_q;
        end
      end
      default: ;
    endcase
    if (state_q == S_CLR && state_d != S_CLR) begin
      clr_item_d = 1'b0;
    end
  end

  assign out_vld_d = (out_vld_q && !m_axis_tready) || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      mode_q      <= SCAN_FREE;
      phase_q     <= PH_FIRST;
      scan_addr_q <= '0;
      rd_vld_q    <= 1'b0;
      count_q     <= '0;
      seq_q       <= '0;
      clr_item_q  <= 1'b0;
      out_vld_q   <= 1'b0;
      cfg_temp_q  <= TAU_W'(256);
      cfg_eps_q   <= EPS_W'(65536);
      cfg_size_q  <= 1'b0;
      cfg_wgt_q   <= 1'b0;
      cfg_ties_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      phase_q     <= phase_d;
      scan_addr_q <= scan_addr_d;
      rd_vld_q    <= rd_vld_d;
      count_q     <= count_d;
      seq_q       <= seq_d;
      clr_item_q  <= clr_item_d;
      out_vld_q   <= out_vld_d;
      if (cfg_we) begin
        case (paddr[4:2])
          REG_TEMP: cfg_temp_q <= pwdata[TAU_W-1:0];
          REG_EPS:  cfg_eps_q  <= pwdata[EPS_W-1:0];
          REG_SIZE: cfg_size_q <= pwdata[0];
          REG_WGT:  cfg_wgt_q  <= pwdata[0];
          REG_TIES: cfg_ties_q <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;  key_q <= key_d;  pay_q <= pay_d;
    du_q <= du_d;      dp_q <= dp_d;
    rd_addr_q <= rd_addr_d;
    fnd_q <= fnd_d;    best_q <= best_d;  cnt_q <= cnt_d;
    hit_q <= hit_d;    hit_pay_q <= hit_pay_d;  age_q <= age_d;
    have_prev_q <= have_prev_d;  prev_q <= prev_d;
    ck_q <= ck_d;      cc_q <= cc_d;
    bk_key_q <= bk_key_d;  bk_cnt_q <= bk_cnt_d;  target_q <= target_d;
    rnd_q <= rnd_d;
    total_q <= total_d;  cum_q <= cum_d;  val_q <= val_d;  nb_q <= nb_d;
    mul_acc_q <= mul_acc_d;  mul_a_q <= mul_a_d;  mul_b_q <= mul_b_d;
    mul_cnt_q <= mul_cnt_d;  prod_a_q <= prod_a_d;
    res_pay_q <= res_pay_d;  res_vld_q <= res_vld_d;  res_st_q <= res_st_d;
    if (load) begin
      out_data_q <= res_pay_q;
      out_user_q <= {res_st_q, (count_q == '0), res_vld_q};
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_TEMP: prdata = 32'(cfg_temp_q);
      REG_EPS:  prdata = 32'(cfg_eps_q);
      REG_SIZE: prdata = 32'(cfg_size_q);
      REG_WGT:  prdata = 32'(cfg_wgt_q);
      REG_TIES: prdata = 32'(cfg_ties_q);
      default:  prdata = '0;
    endcase
  end

  assign pready        = 1'b1;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ----- rtl/sbol_checker.sv -----
module sbol_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser
);
  import sbol_pkg::*;

  // hold a stalled beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[3:2] == STATUS_OK)
    else $error("removed entry with error status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("payload without removal");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[3:2] == STATUS_EMPTY |-> m_axis_tuser[1])
    else $error("remove on empty left store non-empty");

endmodule

bind softmin_bucket_open_list sbol_checker u_sbol_checker (.*);

// ----- tb/softmin_bucket_open_list_chk.sv -----
`timescale 1ns / 1ps

module softmin_bucket_open_list_chk
  import sbol_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic [3:0]  m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [31:0] payload;
    logic        valid;
    logic        empty;
    logic [1:0]  status;
  } outcome_t;

  outcome_t outcome_q[$];

  logic [15:0] tau;
  logic [16:0] eps;
  logic        flat_size;
  logic        flat_weight;
  logic        ties_mode;

  logic [15:0] store_key[CAPACITY];
  logic [31:0] store_seq[CAPACITY];
  logic [31:0] store_pay[CAPACITY];
  bit          store_used[CAPACITY];
  int unsigned store_count;
  logic [31:0] seq_next;
  logic [31:0] halve_tab[16];

  initial begin
    halve_tab = '{32'd3037000500, 32'd3611622603, 32'd3938502376, 32'd4112874773,
                  32'd4202935003, 32'd4248701952, 32'd4271771996, 32'd4283353945,
                  32'd4289156690, 32'd4292061010, 32'd4293513907, 32'd4294240540,
                  32'd4294603903, 32'd4294785596, 32'd4294876445, 32'd4294921870};
  end

  function automatic logic [63:0] exp_weight(logic [15:0] k);
    logic [63:0] t, den, m;
    den = (tau == 0) ? 64'd1 : 64'(tau);
    t = (64'(k) * 64'd256 * 64'd94548) / den;
    if ((t >> 16) >= 25) return 64'd0;
    m = 64'd1 << 32;
    for (int b = 0; b < 16; b++)
      if (t[15 - b]) m = (m * 64'(halve_tab[b])) >> 32;
    return (m >> 8) >> (t >> 16);
  endfunction

  function automatic logic [63:0] bucket_mass(logic [15:0] k, int unsigned c);
    logic [63:0] v;
    v = flat_size ? 64'd1 : 64'(c);
    if (!flat_weight) v = v * exp_weight(k);
    return v;
  endfunction

  function automatic outcome_t step_store(logic [1:0] func, logic [15:0] k, logic [31:0] pay,
                                          logic [15:0] du, logic [15:0] dp);
    outcome_t r;
    int unsigned buckets[logic [15:0]];
    logic [15:0] ck, bk;
    int unsigned cc, target, seen, pick;
    logic [63:0] total, cum;
    logic [31:0] age, best_age;
    bit rnd, more;
    r = '0;
    pick = CAPACITY;
    if (func == FUNC_INSERT) begin
      if (store_count >= CAPACITY) begin
        r.status = STATUS_FULL;
      end else begin
        for (int i = 0; i < CAPACITY; i++)
          if (!store_used[i] && pick == CAPACITY) pick = i;
        store_used[pick] = 1'b1;
        store_key[pick] = k;
        store_pay[pick] = pay;
        store_seq[pick] = seq_next;
        seq_next++;
        store_count++;
      end
    end else if (func == FUNC_REMOVE) begin
      for (int i = 0; i < CAPACITY; i++)
        if (store_used[i]) buckets[store_key[i]]++;
      if (buckets.size() == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        void'(buckets.first(ck));
        cc = buckets[ck];
        rnd = 17'(du) <= eps;
        if (rnd && !ties_mode && buckets.size() > 1) begin
          total = 0;
          foreach (buckets[b]) total += bucket_mass(b, buckets[b]);
          cum = 0;
          more = buckets.first(bk);
          while (more) begin
            cum += bucket_mass(bk, buckets[bk]);
            if (64'(du) * total <= cum * 64'(eps)) begin
              ck = bk;
              cc = buckets[bk];
              more = 0;
            end else begin
              more = buckets.next(bk);
            end
          end
        end
        if (rnd) begin
          target = (32'(dp) * cc) >> 16;
          seen = 0;
          for (int i = 0; i < CAPACITY; i++)
            if (store_used[i] && store_key[i] == ck && pick == CAPACITY) begin
              if (seen == target) pick = i;
              seen++;
            end
        end else begin
          best_age = 0;
          for (int i = 0; i < CAPACITY; i++)
            if (store_used[i] && store_key[i] == ck) begin
              age = seq_next - store_seq[i];
              if (pick == CAPACITY || age > best_age) begin
                pick = i;
                best_age = age;
              end
            end
        end
        if (pick < CAPACITY) begin
          r.payload = store_pay[pick];
          r.valid = 1'b1;
          store_used[pick] = 1'b0;
          if (store_count != 0) store_count--;
        end
      end
    end else if (func == FUNC_CLEAR) begin
      for (int i = 0; i < CAPACITY; i++) store_used[i] = 1'b0;
      store_count = 0;
    end
    r.empty = (store_count == 0);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want, got;
    if (!rst_ni) begin
      tau <= 16'd256;
      eps <= 17'd65536;
      flat_size <= 1'b0;
      flat_weight <= 1'b0;
      ties_mode <= 1'b0;
      store_count = 0;
      seq_next = '0;
      for (int i = 0; i < CAPACITY; i++) store_used[i] = 1'b0;
      outcome_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1], m_axis_tuser[3:2]};
        if (outcome_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = outcome_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("mismatch: payload %h/%h valid %b/%b empty %b/%b status %0d/%0d",
                       want.payload, got.payload, want.valid, got.valid,
                       want.empty, got.empty, want.status, got.status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        outcome_q.push_back(step_store(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[47:16],
                                       s_axis_tdata[63:48], s_axis_tdata[79:64]));
      pending <= outcome_q.size();
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_TEMP: tau <= pwdata[15:0];
          REG_EPS:  eps <= pwdata[16:0];
          REG_SIZE: flat_size <= pwdata[0];
          REG_WGT:  flat_weight <= pwdata[0];
          REG_TIES: ties_mode <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- tb/softmin_bucket_open_list_tb.sv -----
`timescale 1ns / 1ps

module softmin_bucket_open_list_tb;
  import sbol_pkg::*;

  localparam logic [1:0] FUNC_SPARE = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;   // key, payload, draw_unit, draw_pick
  logic [1:0]  s_axis_tuser = '0;   // func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // removed_payload
  logic [3:0]  m_axis_tuser;        // removed_valid, now_empty, status
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;

  bit          gaps_on = 1'b1;
  bit          hold_req = 1'b0;
  logic [15:0] key_pool[6];

  softmin_bucket_open_list dut (.*);

  softmin_bucket_open_list_chk chk (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #(64'd1_000_000_000);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int stall;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (3000) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 16);
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
      @(posedge clk_i);
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic set_mode(logic [15:0] t, logic [16:0] e, bit sz, bit wg, bit ti);
    drain();
    reg_write(REG_TEMP, 32'(t));
    reg_write(REG_EPS, 32'(e));
    reg_write(REG_SIZE, 32'(sz));
    reg_write(REG_WGT, 32'(wg));
    reg_write(REG_TIES, 32'(ti));
  endtask

  task automatic send_beat(logic [1:0] func, logic [15:0] k, logic [31:0] pay,
                           logic [15:0] du, logic [15:0] dp, bit last);
    bit gap;
    int idle;
    s_axis_tdata <= {dp, du, pay, k};
    s_axis_tuser <= func;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    gap = gaps_on && $urandom_range(0, 5) == 0;
    if (gap || last) s_axis_tvalid <= 1'b0;
    if (gap) begin
      idle = $urandom_range(1, 16);
      repeat (idle) @(posedge clk_i);
    end
  endtask

  task automatic fill_pool();
    for (int i = 0; i < 6; i++)
      case ($urandom_range(0, 5))
        0: key_pool[i] = 16'd0;
        1: key_pool[i] = 16'hFFFF;
        2, 3: key_pool[i] = 16'($urandom_range(0, 15));
        default: key_pool[i] = 16'($urandom);
      endcase
  endtask

  task automatic random_beat(int ins_pct, bit last);
    int r;
    logic [1:0] func;
    r = $urandom_range(0, 99);
    if (r < ins_pct) func = FUNC_INSERT;
    else if (r < 94) func = FUNC_REMOVE;
    else if (r < 97) func = FUNC_CLEAR;
    else func = FUNC_SPARE;
    send_beat(func, key_pool[$urandom_range(0, 5)], $urandom, 16'($urandom), 16'($urandom),
              last);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(FUNC_REMOVE, 16'd0, 32'd0, 16'd0, 16'd0, 0);
    send_beat(FUNC_SPARE, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 0);
    send_beat(FUNC_INSERT, 16'd0, 32'hFFFFFFFF, 16'hFFFF, 16'd0, 0);
    send_beat(FUNC_INSERT, 16'hFFFF, 32'd0, 16'd0, 16'hFFFF, 0);
    send_beat(FUNC_INSERT, 16'd0, 32'h5A5A5A5A, 16'd0, 16'd0, 0);
    send_beat(FUNC_INSERT, 16'd1, 32'hA5A5A5A5, 16'd0, 16'd0, 0);
    send_beat(FUNC_REMOVE, 16'd0, 32'd0, 16'd0, 16'hFFFF, 0);
    send_beat(FUNC_REMOVE, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'd0, 0);
    send_beat(FUNC_CLEAR, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 0);
    send_beat(FUNC_REMOVE, 16'd0, 32'd0, 16'd0, 16'd0, 0);
    send_beat(FUNC_INSERT, 16'd7, 32'd11, 16'd0, 16'd0, 0);
    send_beat(FUNC_INSERT, 16'd7, 32'd12, 16'd0, 16'd0, 1);
    set_mode(16'd0, 17'h1FFFF, 1'b1, 1'b1, 1'b1);
    send_beat(FUNC_INSERT, 16'd3, 32'd13, 16'hFFFF, 16'd0, 0);
    send_beat(FUNC_REMOVE, 16'd0, 32'd0, 16'hFFFF, 16'hFFFF, 0);
    send_beat(FUNC_REMOVE, 16'd0, 32'd0, 16'd0, 16'd0, 1);
    set_mode(16'hFFFF, 17'd0, 1'b0, 1'b0, 1'b0);
    send_beat(FUNC_INSERT, 16'd2, 32'd21, 16'd0, 16'd0, 0);
    send_beat(FUNC_INSERT, 16'd2, 32'd22, 16'd0, 16'd0, 0);
    send_beat(FUNC_REMOVE, 16'd0, 32'd0, 16'd1, 16'd0, 0);
    send_beat(FUNC_REMOVE, 16'd0, 32'd0, 16'd0, 16'd0, 0);
    send_beat(FUNC_CLEAR, 16'd0, 32'd0, 16'd0, 16'd0, 1);

    set_mode(16'd512, 17'd20000, 1'b0, 1'b0, 1'b0);
    fill_pool();
    for (int i = 0; i < 1030; i++)
      send_beat(FUNC_INSERT, key_pool[$urandom_range(0, 5)], $urandom, 16'($urandom),
                16'($urandom), 0);
    for (int i = 0; i < 6; i++) random_beat(0, 0);
    hold_req = 1'b1;
    for (int i = 0; i < 4; i++) random_beat(50, 0);
    send_beat(FUNC_CLEAR, 16'd0, 32'd0, 16'd0, 16'd0, 1);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_mode(16'd256, 17'd65536, 1'b0, 1'b0, 1'b0);
        1: set_mode(16'd1, 17'd0, 1'b0, 1'b0, 1'b0);
        2: set_mode(16'hFFFF, 17'd32768, 1'b1, 1'b0, 1'b0);
        3: set_mode(16'd0, 17'h1FFFF, 1'b0, 1'b1, 1'b0);
        4: set_mode(16'd300, 17'd50000, 1'b1, 1'b1, 1'b0);
        default: begin
          gaps_on = 1'b0;
          set_mode(16'd4096, 17'd65536, 1'b0, 1'b0, 1'b1);
        end
      endcase
      fill_pool();
      for (int i = 0; i < 25; i++) random_beat(ph == 1 ? 50 : 60, i == 24);
    end

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sbol_pkg.sv
rtl/sbol_ram.sv
rtl/sbol_weight.sv
rtl/softmin_bucket_open_list.sv
rtl/sbol_checker.sv
tb/softmin_bucket_open_list_chk.sv
tb/softmin_bucket_open_list_tb.sv
